/* design/pit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_pkg: shared types and constants of the periodic interval timer
// Request codes, register offsets, mode bit positions and the request item.
// ----------------------------------------------------------------------------
package pit_pkg;

    // Request kinds carried in the low bits of the input word.
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } req_t;

    // Register word offsets.
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_STATUS = 2'd1;
    localparam logic [1:0] REG_VALUE  = 2'd2;
    localparam logic [1:0] REG_IMAGE  = 2'd3;

    // Mode register bit positions.
    localparam int MODE_EN_BIT  = 24;
    localparam int MODE_IEN_BIT = 25;

    // Prescaler ratio after reset.
    localparam int          DIV_BITS      = 16;
    localparam logic [15:0] DIVIDER_RESET = 16'd16;

    // One request as it travels between the input stage and the core.
    typedef struct packed {
        logic [31:0] write_data;
        logic [1:0]  reg_index;
        logic [1:0]  req_type;
    } item_t;

endpackage

/* design/pit_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_in_stage: input register of the periodic interval timer
// Captures one request per cycle while the core keeps taking them, and holds it until the core takes it.
// ----------------------------------------------------------------------------
module pit_in_stage
    import pit_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The stage takes a new request when empty or when its content moves on.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on each accepted request.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/pit_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_core: timer state, register file and result register
// Applies one request per cycle, while the result register is free or being taken, to
// the prescaler, interval value and registers, and registers the read data and interrupt level.
// ----------------------------------------------------------------------------
module pit_core
    import pit_pkg::*;
#(
    parameter int VALUE_BITS = 20,
    parameter int COUNT_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [DIV_BITS-1:0] cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  item_t               in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_read_data,
    output logic                out_irq
);

    localparam int IMG_BITS = VALUE_BITS + COUNT_BITS;

    // State registers.
    logic [DIV_BITS-1:0]   divider_reg;
    logic [DIV_BITS-1:0]   pcount_reg,  pcount_next;
    logic [VALUE_BITS-1:0] value_reg,   value_next;
    logic [COUNT_BITS-1:0] ovf_reg,     ovf_next;
    logic                  flag_reg,    flag_next;
    logic [VALUE_BITS-1:0] limit_reg,   limit_next;
    logic                  en_reg,      en_next;
    logic                  ien_reg,     ien_next;

    // Result register.
    logic                  rvalid_reg,  rvalid_next;
    logic [31:0]           rdata_reg,   rdata_next;
    logic                  irq_reg,     irq_next;

    logic                  fire;
    req_t                  req;
    logic [DIV_BITS:0]     acc;
    logic [VALUE_BITS:0]   value_inc;
    logic [IMG_BITS+31:0]  image_wide;
    logic [VALUE_BITS+31:0] limit_wide;
    logic [31:0]           mode_word;

    assign in_ready = !rvalid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign req      = req_t'(in_item.req_type);

    // Register read words.
    assign image_wide = {32'd0, ovf_reg, value_reg};
    assign limit_wide = {32'd0, limit_reg};
    always_comb
    begin
        mode_word               = limit_wide[31:0];
        mode_word[MODE_EN_BIT]  = mode_word[MODE_EN_BIT] | en_reg;
        mode_word[MODE_IEN_BIT] = mode_word[MODE_IEN_BIT] | ien_reg;
    end

    assign acc       = {1'b0, pcount_reg} + {{DIV_BITS{1'b0}}, 1'b1};
    assign value_inc = {1'b0, value_reg} + {{VALUE_BITS{1'b0}}, 1'b1};

    // Next state for the current request.
    always_comb
    begin
        pcount_next = pcount_reg;
        value_next  = value_reg;
        ovf_next    = ovf_reg;
        flag_next   = flag_reg;
        limit_next  = limit_reg;
        en_next     = en_reg;
        ien_next    = ien_reg;
        rdata_next  = 32'd0;

        case (req)
            REQ_TICK:
            begin
                if (divider_reg != '0)
                begin
                    if (acc >= {1'b0, divider_reg})
                    begin
                        // One timer count: advance or wrap the interval value.
                        pcount_next = '0;
                        if (value_inc > {1'b0, limit_reg})
                        begin
                            value_next = '0;
                            ovf_next   = ovf_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};
                            flag_next  = 1'b1;
                        end
                        else
                        begin
                            value_next = value_inc[VALUE_BITS-1:0];
                        end
                    end
                    else
                    begin
                        pcount_next = acc[DIV_BITS-1:0];
                    end
                end
            end
            REQ_READ:
            begin
                case (in_item.reg_index)
                    REG_MODE:   rdata_next = mode_word;
                    REG_STATUS: rdata_next = {31'd0, flag_reg};
                    REG_VALUE:
                    begin
                        // Reading the value clears the count and the flag.
                        rdata_next = image_wide[31:0];
                        ovf_next   = '0;
                        flag_next  = 1'b0;
                    end
                    default:    rdata_next = image_wide[31:0];
                endcase
            end
            REQ_WRITE:
            begin
                if (in_item.reg_index == REG_MODE)
                begin
                    limit_next = in_item.write_data[VALUE_BITS-1:0];
                    en_next    = in_item.write_data[MODE_EN_BIT];
                    ien_next   = in_item.write_data[MODE_IEN_BIT];
                end
            end
            default:
            begin
                rdata_next = 32'd0;
            end
        endcase

        irq_next = flag_next & ien_next;
    end

    assign rvalid_next = fire ? 1'b1 : (out_ready ? 1'b0 : rvalid_reg);

    // Control and timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg <= DIVIDER_RESET;
            pcount_reg  <= '0;
            value_reg   <= '0;
            ovf_reg     <= '0;
            flag_reg    <= 1'b0;
            limit_reg   <= '0;
            en_reg      <= 1'b0;
            ien_reg     <= 1'b0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            rvalid_reg <= rvalid_next;
            if (cfg_we)
            begin
                divider_reg <= cfg_wdata;
            end
            if (fire)
            begin
                pcount_reg <= pcount_next;
                value_reg  <= value_next;
                ovf_reg    <= ovf_next;
                flag_reg   <= flag_next;
                limit_reg  <= limit_next;
                en_reg     <= en_next;
                ien_reg    <= ien_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

    assign out_valid     = rvalid_reg;
    assign out_read_data = rdata_reg;
    assign out_irq       = irq_reg;

endmodule

/* design/periodic_interval_timer_unit.sv */
// Path: a request is held in the input register, and its result in the result register.
// Throughput: one request per cycle; the input register and the result
// register form a two-stage pipeline with backpressure from m_axis_tready.
// Reset: rst_n clears all timer state and the mode fields, empties both
// stages, and loads the prescaler ratio with 16.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_interval_timer_unit: periodic interval timer, top level
// Stream front end for tick, register read and register write requests,
// with a write-only prescaler ratio register.
// ----------------------------------------------------------------------------
module periodic_interval_timer_unit
    import pit_pkg::*;
#(
    parameter int VALUE_BITS = 20,
    parameter int COUNT_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Prescaler ratio register.
    input  logic                cfg_we,
    input  logic [DIV_BITS-1:0] cfg_wdata,
    // Requests.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,  // write_data[31:0]
    input  logic [3:0]          s_axis_tuser,  // req_type[1:0], reg_index[3:2]
    // Results.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata   // read_data[31:0], irq[32],
                                               // zero fill
);

    item_t       in_item;
    item_t       core_item;
    logic        core_valid;
    logic        core_ready;
    logic [31:0] read_data;
    logic        irq;

    // Unpack the request kind, register offset and data word.
    assign in_item.req_type   = s_axis_tuser[1:0];
    assign in_item.reg_index  = s_axis_tuser[3:2];
    assign in_item.write_data = s_axis_tdata;

    pit_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    pit_core #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (core_valid),
        .in_ready      (core_ready),
        .in_item       (core_item),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_read_data (read_data),
        .out_irq       (irq)
    );

    // Pack the result word.
    assign m_axis_tdata = {7'd0, irq, read_data};

endmodule

/* sim/pit_response_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_response_monitor: response predictor and comparator for the timer
// Watches the request, response and ratio register ports, keeps its own copy
// of the timer state, and compares each response against the oldest expected.
// ----------------------------------------------------------------------------
module pit_response_monitor
    import pit_pkg::*;
#(
    parameter int VALUE_BITS = 20,
    parameter int COUNT_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [DIV_BITS-1:0] cfg_wdata,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,  // write_data[31:0]
    input  logic [3:0]          s_axis_tuser,  // req_type[1:0], reg_index[3:2]
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [39:0]         m_axis_tdata,  // read_data[31:0], irq[32],
                                               // zero fill
    output int                  outstanding,
    output int                  fail_count
);

    typedef struct packed {
        logic        irq;
        logic [31:0] read_data;
    } response_t;

    // Shadow copy of the timer state.
    logic [DIV_BITS-1:0]   ratio;
    logic [DIV_BITS-1:0]   prescale_cnt;
    logic [VALUE_BITS-1:0] timer_value;
    logic [COUNT_BITS-1:0] wrap_count;
    logic                  wrap_flag;
    logic [VALUE_BITS-1:0] interval_limit;
    logic                  timer_en;
    logic                  irq_en;

    response_t expected_responses[$];

    // Value register layout: wrap count above the interval value.
    function automatic logic [31:0] image_word();
        logic [63:0] w;
        w = (64'(wrap_count) << VALUE_BITS) | 64'(timer_value);
        return w[31:0];
    endfunction

    // One master tick through the prescaler, and one timer count when it rolls.
    task automatic master_tick();
        if (ratio != '0)
        begin
            if ((17'(prescale_cnt) + 17'd1) >= 17'(ratio))
            begin
                prescale_cnt = '0;
                if ((VALUE_BITS+1)'(timer_value) + 1'b1 > (VALUE_BITS+1)'(interval_limit))
                begin
                    timer_value = '0;
                    wrap_count  = wrap_count + 1'b1;
                    wrap_flag   = 1'b1;
                end
                else
                begin
                    timer_value = timer_value + 1'b1;
                end
            end
            else
            begin
                prescale_cnt = prescale_cnt + 1'b1;
            end
        end
    endtask

    // Applies one request to the shadow state and yields its response.
    task automatic predict_response(input item_t req, output response_t rsp);
        logic [31:0] rdata;
        rdata = '0;
        if (req.req_type == REQ_TICK)
        begin
            master_tick();
        end
        else if (req.req_type == REQ_READ)
        begin
            case (req.reg_index)
                REG_MODE:
                begin
                    rdata = 32'(interval_limit);
                    rdata[MODE_EN_BIT]  = timer_en;
                    rdata[MODE_IEN_BIT] = irq_en;
                end
                REG_STATUS: rdata = {31'b0, wrap_flag};
                REG_VALUE:
                begin
                    rdata      = image_word();
                    wrap_count = '0;
                    wrap_flag  = 1'b0;
                end
                default: rdata = image_word();
            endcase
        end
        else if (req.req_type == REQ_WRITE)
        begin
            // Only the mode register is writable; other bits are dropped.
            if (req.reg_index == REG_MODE)
            begin
                interval_limit = req.write_data[VALUE_BITS-1:0];
                timer_en       = req.write_data[MODE_EN_BIT];
                irq_en         = req.write_data[MODE_IEN_BIT];
            end
        end
        rsp.read_data = rdata;
        rsp.irq       = wrap_flag & irq_en;
    endtask

    // Sample all ports at the rising edge; compare first, then predict.
    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        response_t got;
        if (!rst_n)
        begin
            ratio          = DIVIDER_RESET;
            prescale_cnt   = '0;
            timer_value    = '0;
            wrap_count     = '0;
            wrap_flag      = 1'b0;
            interval_limit = '0;
            timer_en       = 1'b0;
            irq_en         = 1'b0;
            fail_count     = 0;
            expected_responses.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.read_data = m_axis_tdata[31:0];
                got.irq       = m_axis_tdata[32];
                if (expected_responses.size() == 0)
                begin
                    $error("response with no request waiting: tdata %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (got.read_data !== want.read_data)
                    begin
                        $error("read_data mismatch: expected %h, actual %h",
                               want.read_data, got.read_data);
                        fail_count++;
                    end
                    if (got.irq !== want.irq)
                    begin
                        $error("irq mismatch: expected %b, actual %b", want.irq, got.irq);
                        fail_count++;
                    end
                    if (m_axis_tdata[39:33] !== 7'b0)
                    begin
                        $error("zero fill mismatch: expected %h, actual %h",
                               7'b0, m_axis_tdata[39:33]);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                ratio = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_response(item_t'({s_axis_tdata, s_axis_tuser}), want);
                expected_responses.push_back(want);
            end
        end
        outstanding = expected_responses.size();
    end

endmodule

/* sim/tb_periodic_interval_timer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_interval_timer_unit: testbench top of the interval timer
// Drives directed and random tick, read, write and unused-kind requests with random gaps
// and response stalls across several prescaler ratios; a monitor checks.
// ----------------------------------------------------------------------------
module tb_periodic_interval_timer_unit;
    import pit_pkg::*;

    // Request kind that the block treats as a no-op.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         LATENCY    = 2;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [DIV_BITS-1:0] cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata  = '0;  // write_data[31:0]
    logic [3:0]          s_axis_tuser  = '0;  // req_type[1:0], reg_index[3:2]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [39:0]         m_axis_tdata;        // read_data[31:0], irq[32], zero fill
    int                  outstanding;
    int                  fail_count;
    bit                  tx_quiet      = 1'b0;

    always #6 clk = ~clk;

    periodic_interval_timer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pit_response_monitor u_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .outstanding   (outstanding),
        .fail_count    (fail_count)
    );

    function automatic item_t make_req(logic [1:0] kind, logic [1:0] idx, logic [31:0] data);
        item_t req;
        req.req_type   = kind;
        req.reg_index  = idx;
        req.write_data = data;
        return req;
    endfunction

    // Random request: mostly ticks, with reads, mode writes using short
    // intervals so that wraps happen often, and some noise.
    function automatic item_t random_req();
        int          pick;
        logic [31:0] data;
        logic [1:0]  idx;
        pick = $urandom_range(0, 99);
        data = $urandom;
        idx  = 2'($urandom_range(0, 3));
        if (pick < 55)
        begin
            return make_req(REQ_TICK, idx, data);
        end
        else if (pick < 75)
        begin
            return make_req(REQ_READ, idx, data);
        end
        else if (pick < 93)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                idx = REG_MODE;
            end
            if ($urandom_range(0, 7) != 0)
            begin
                data[19:0] = 20'($urandom_range(0, 12));
            end
            return make_req(REQ_WRITE, idx, data);
        end
        return make_req(REQ_UNUSED, idx, data);
    endfunction

    // Presents one request after a random gap and waits for its acceptance.
    task automatic send_request(input item_t req);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req.write_data;
        s_axis_tuser  <= {req.reg_index, req.req_type};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Waits until every response is back and the pipeline has drained.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic set_ratio(input logic [DIV_BITS-1:0] value);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Response side: random stall before each response, with stall-free stretches.
    initial
    begin
        int stall;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        wait (rst_n);
        forever
        begin
            if (taken % 40 == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            stall = quiet ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            taken++;
        end
    end

    // Request side: directed checks, then random phases over several ratios.
    initial
    begin
        logic [DIV_BITS-1:0] ratios[8];
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every register reads zero after reset.
        send_request(make_req(REQ_READ, REG_MODE, 32'h0));
        send_request(make_req(REQ_READ, REG_STATUS, 32'h0));
        send_request(make_req(REQ_READ, REG_VALUE, 32'h0));
        send_request(make_req(REQ_READ, REG_IMAGE, 32'h0));
        // All-ones mode write keeps only interval, enable and interrupt enable.
        send_request(make_req(REQ_WRITE, REG_MODE, 32'hFFFF_FFFF));
        send_request(make_req(REQ_READ, REG_MODE, 32'hFFFF_FFFF));
        // Writes to the read-only registers and the unused kind do nothing.
        send_request(make_req(REQ_WRITE, REG_STATUS, 32'hFFFF_FFFF));
        send_request(make_req(REQ_WRITE, REG_VALUE, 32'hFFFF_FFFF));
        send_request(make_req(REQ_WRITE, REG_IMAGE, 32'hFFFF_FFFF));
        send_request(make_req(REQ_UNUSED, REG_IMAGE, 32'hFFFF_FFFF));
        repeat (10) send_request(make_req(REQ_TICK, REG_MODE, 32'h0));

        // Ratio lowered below the prescaler count: next tick makes one count.
        set_ratio(16'd3);
        send_request(make_req(REQ_TICK, REG_MODE, 32'h0));
        send_request(make_req(REQ_READ, REG_IMAGE, 32'h0));

        // Interval lowered below the value: the next count wraps once.
        set_ratio(16'd1);
        send_request(make_req(REQ_WRITE, REG_MODE, 32'h0200_0005));
        repeat (4) send_request(make_req(REQ_TICK, REG_MODE, 32'h0));
        send_request(make_req(REQ_WRITE, REG_MODE, 32'h0200_0001));
        send_request(make_req(REQ_TICK, REG_MODE, 32'h0));
        send_request(make_req(REQ_READ, REG_STATUS, 32'h0));
        send_request(make_req(REQ_READ, REG_VALUE, 32'h0));
        send_request(make_req(REQ_READ, REG_STATUS, 32'h0));

        // Random phases, including the zero ratio and the largest one.
        ratios = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd5,
                   DIV_BITS'($urandom_range(1, 7)), 16'd1, DIV_BITS'($urandom)};
        foreach (ratios[p])
        begin
            set_ratio(ratios[p]);
            for (int n = 0; n < 100; n++)
            begin
                if (n % 50 == 0)
                begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                end
                send_request(random_req());
            end
        end

        drain();
        repeat (LATENCY + 8) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("periodic_interval_timer_unit test passed");
        end
        else
        begin
            $display("periodic_interval_timer_unit test failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a lost response.
    initial
    begin
        #5_000_000;
        $display("periodic_interval_timer_unit test failed");
        $finish;
    end

endmodule
